[src/fpba_pkg.sv]
// fpba_pkg: shared types, constants and codes for the fit-policy block allocator.
// Has no dependencies; every module in src imports it.
`default_nettype none

package fpba_pkg;

	localparam int NUM_BLOCKS_DEF = 16;
	localparam int SIZE_BITS_DEF  = 16;

	// fixed field widths of the request, result and configuration ports
	localparam int IDX_FIELD_W  = 4;
	localparam int AMT_FIELD_W  = 16;
	localparam int MODE_W       = 2;
	localparam int COUNT_W      = 5;
	localparam int CFG_IDX_W    = 1;
	localparam int CFG_DATA_W   = 5;

	// fit_mode codes; the unused code behaves as first fit
	localparam logic [MODE_W-1:0] MODE_FIRST = 2'd0;
	localparam logic [MODE_W-1:0] MODE_BEST  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_WORST = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_FIT_MODE    = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = 1'd1;

	// request kinds
	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_ALLOC = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_FINISH
	} fpba_state_t;

	typedef struct packed {
		logic                   granted;
		logic [IDX_FIELD_W-1:0] chosen_block;
		logic [AMT_FIELD_W-1:0] remaining_size;
	} fpba_res_t;

endpackage

`default_nettype wire

[src/fpba_table.sv]
// fpba_table: free-size memory, one write port and one registered read port.
// Depends on fpba_pkg for nothing but house conventions.
`default_nettype none

module fpba_table #(
	parameter int NUM_BLOCKS = 16,
	parameter int SIZE_BITS  = 16
) (
	input  wire logic                          clk,
	input  wire logic                          we,
	input  wire logic [$clog2(NUM_BLOCKS)-1:0] waddr,
	input  wire logic [SIZE_BITS-1:0]          wdata,
	input  wire logic [$clog2(NUM_BLOCKS)-1:0] raddr,
	output logic      [SIZE_BITS-1:0]          rdata
);
	import fpba_pkg::*;

	logic [SIZE_BITS-1:0] mem_q [NUM_BLOCKS];
	logic [SIZE_BITS-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

[src/fpba_ctrl.sv]
// fpba_ctrl: scan sequencer with the shared compare/subtract unit.
// Depends on fpba_pkg and fpba_table.
`default_nettype none

module fpba_ctrl #(
	parameter int NUM_BLOCKS = 16,
	parameter int SIZE_BITS  = 16
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                req_valid,
	output logic                                     req_ready,
	input  wire logic                                req_type,
	input  wire logic [fpba_pkg::IDX_FIELD_W-1:0]    load_index,
	input  wire logic [fpba_pkg::AMT_FIELD_W-1:0]    amount,
	input  wire logic [fpba_pkg::MODE_W-1:0]         fit_mode,
	input  wire logic [$clog2(NUM_BLOCKS+1)-1:0]     used,
	input  wire logic                                slot_free,
	output logic                                     res_valid,
	output fpba_pkg::fpba_res_t                      res
);
	import fpba_pkg::*;

	localparam int IDX_W = $clog2(NUM_BLOCKS);
	localparam int CNT_W = $clog2(NUM_BLOCKS + 1);

	fpba_state_t          state_q, state_d;
	logic [CNT_W-1:0]     cnt_q;
	logic [IDX_W-1:0]     idx_s1;
	logic                 vld_s1;
	logic [SIZE_BITS-1:0] amt_q;
	logic [SIZE_BITS-1:0] best_q;
	logic [IDX_W-1:0]     pick_q;
	logic                 found_q;

	logic                 mem_we;
	logic [IDX_W-1:0]     mem_waddr;
	logic [SIZE_BITS-1:0] mem_wdata;
	logic [SIZE_BITS-1:0] mem_rdata;
	logic                 fits, take;
	logic [SIZE_BITS-1:0] left;
	logic                 accept, load_ok;

	fpba_table #(
		.NUM_BLOCKS(NUM_BLOCKS),
		.SIZE_BITS (SIZE_BITS)
	) u_table (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(cnt_q[IDX_W-1:0]),
		.rdata(mem_rdata)
	);

	// shared compare/subtract unit
	assign fits = (mem_rdata >= amt_q);
	assign left = best_q - amt_q;

	always_comb begin
		take = 1'b0;
		if (vld_s1 && fits) begin
			if (!found_q) begin
				take = 1'b1;
			end else begin
				case (fit_mode)
					MODE_BEST:  take = (mem_rdata < best_q);
					MODE_WORST: take = (mem_rdata > best_q);
					default:    take = 1'b0;
				endcase
			end
		end
	end

	assign req_ready = (state_q == ST_IDLE);
	assign accept    = req_valid && req_ready;
	assign load_ok   = (32'(load_index) < NUM_BLOCKS);

	always_comb begin
		state_d   = state_q;
		mem_we    = 1'b0;
		mem_waddr = IDX_W'(load_index);
		mem_wdata = SIZE_BITS'(amount);
		res_valid = 1'b0;
		res       = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (req_type == REQ_LOAD) begin
						mem_we = load_ok;
					end else if (used == '0) begin
						state_d = ST_FINISH;
					end else begin
						state_d = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				if (CNT_W'(cnt_q + 1'b1) == used) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (slot_free) begin
					res_valid = 1'b1;
					if (found_q) begin
						mem_we             = 1'b1;
						mem_waddr          = pick_q;
						mem_wdata          = left;
						res.granted        = 1'b1;
						res.chosen_block   = IDX_FIELD_W'(pick_q);
						res.remaining_size = AMT_FIELD_W'(left);
					end
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			vld_s1  <= 1'b0;
			found_q <= 1'b0;
		end else begin
			state_q <= state_d;
			vld_s1  <= (state_q == ST_SCAN);
			if (state_q == ST_SCAN) begin
				cnt_q <= CNT_W'(cnt_q + 1'b1);
			end else begin
				cnt_q <= '0;
			end
			if (accept) begin
				found_q <= 1'b0;
			end else if (take) begin
				found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= cnt_q[IDX_W-1:0];
		if (accept) begin
			amt_q <= SIZE_BITS'(amount);
		end
		if (take) begin
			best_q <= mem_rdata;
			pick_q <= idx_s1;
		end
	end

endmodule

`default_nettype wire

[src/fit_policy_block_allocator_top.sv]
// fit_policy_block_allocator_top: stream wrapper, configuration registers and
// result register around fpba_ctrl. Depends on fpba_pkg, fpba_ctrl, fpba_table.
`default_nettype none

// Fit-policy block allocator.
// Requests enter on the s_axis group: tuser carries the kind (load or allocate),
// tdata carries the block index and the amount. A load request writes one
// block's free size and gives no result. An allocate request scans blocks
// 0 .. block_count-1 and picks the first, smallest or largest block that fits,
// as fit_mode says (ties go to the lower index), subtracts the request from it
// and returns one result on the m_axis group: tuser holds the grant flag and
// tdata the block index and the size left.
// Sequence: a load is written to the table at the edge that takes it. An allocate scans
// n blocks, n being block_count capped at NUM_BLOCKS: n table reads, one entry per cycle,
// through the one compare unit, a last compare, then write-back as the result is issued
// (block_count 0 goes straight to the final step). tready is high only idle.
// A finished result sits in an output register; the next request is taken
// while it waits. If the receiver stalls, a following allocate holds in its
// final step until the register empties.
// Reset clears the sequencer, the result register and the configuration
// (first fit, 16 blocks). The size table is not cleared: every block in use
// must be loaded before the first allocate.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once; the user must
// make them only while the block is idle, as the block itself does not enforce it.

module fit_policy_block_allocator_top #(
	parameter int NUM_BLOCKS = fpba_pkg::NUM_BLOCKS_DEF,
	parameter int SIZE_BITS  = fpba_pkg::SIZE_BITS_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	// request channel
	input  wire logic                               s_axis_tvalid,
	output logic                                    s_axis_tready,
	input  wire logic [23:0]                        s_axis_tdata,  // load_index[3:0], amount[19:4], zero pad
	input  wire logic                               s_axis_tuser,  // req_type
	// result channel
	output logic                                    m_axis_tvalid,
	input  wire logic                               m_axis_tready,
	output logic      [23:0]                        m_axis_tdata,  // chosen_block[3:0], remaining_size[19:4], zero pad
	output logic                                    m_axis_tuser,  // granted
	// configuration write port
	input  wire logic                               cfg_we,
	input  wire logic [fpba_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [fpba_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import fpba_pkg::*;

	localparam int CNT_W = $clog2(NUM_BLOCKS + 1);

	logic [MODE_W-1:0]  fit_mode_q;
	logic [COUNT_W-1:0] block_count_q;
	logic [CNT_W-1:0]   used;

	logic       out_valid_q;
	fpba_res_t  out_q;
	fpba_res_t  res;
	logic       res_valid;
	logic       slot_free;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_mode_q    <= MODE_FIRST;
			block_count_q <= COUNT_W'(16);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_FIT_MODE:    fit_mode_q    <= cfg_data[MODE_W-1:0];
				CFG_BLOCK_COUNT: block_count_q <= cfg_data[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// blocks in use, saturated at the table depth
	always_comb begin
		if (32'(block_count_q) > NUM_BLOCKS) begin
			used = CNT_W'(NUM_BLOCKS);
		end else begin
			used = CNT_W'(block_count_q);
		end
	end

	// result register is free when empty or being drained this cycle
	assign slot_free = !out_valid_q || m_axis_tready;

	fpba_ctrl #(
		.NUM_BLOCKS(NUM_BLOCKS),
		.SIZE_BITS (SIZE_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (s_axis_tvalid),
		.req_ready (s_axis_tready),
		.req_type  (s_axis_tuser),
		.load_index(s_axis_tdata[3:0]),
		.amount    (s_axis_tdata[19:4]),
		.fit_mode  (fit_mode_q),
		.used      (used),
		.slot_free (slot_free),
		.res_valid (res_valid),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_q.granted;
	assign m_axis_tdata  = {4'd0, out_q.remaining_size, out_q.chosen_block};

endmodule

`default_nettype wire

[dv/fpba_grant_checker.sv]
`timescale 1ns / 100ps
// fpba_grant_checker: watches the request, result and configuration ports of the
// block allocator, predicts each grant and compares it. Depends on fpba_pkg.

module fpba_grant_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // load_index[3:0], amount[19:4], zero pad
	input  logic        s_axis_tuser,   // req_type
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [23:0] m_axis_tdata,   // chosen_block[3:0], remaining_size[19:4], zero pad
	input  logic        m_axis_tuser,   // granted
	input  logic        cfg_we,
	input  logic [fpba_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [fpba_pkg::CFG_DATA_W-1:0] cfg_data,
	output int          error_count,
	output int          outstanding,
	output int          result_count,
	output int          grant_count
);
	import fpba_pkg::*;

	logic [AMT_FIELD_W-1:0] free_size [NUM_BLOCKS_DEF];
	logic [MODE_W-1:0]      fit_mode_q;
	logic [COUNT_W-1:0]     block_count_q;
	fpba_res_t              grant_q [$];
	fpba_res_t              got;
	fpba_res_t              want;
	int                     errs;
	int                     results;
	int                     grants;

	// pick a block for one allocate request and take the amount out of it
	function automatic fpba_res_t predict_grant(input logic [AMT_FIELD_W-1:0] amt);
		fpba_res_t   res;
		int unsigned in_use;
		int unsigned j;
		int unsigned pick;
		bit          found;
		bit          stop;
		res    = '0;
		found  = 1'b0;
		stop   = 1'b0;
		pick   = 0;
		in_use = (32'(block_count_q) > NUM_BLOCKS_DEF) ? NUM_BLOCKS_DEF : 32'(block_count_q);
		for (j = 0; j < in_use && !stop; j++) begin
			if (free_size[j] >= amt) begin
				if (!found) begin
					pick  = j;
					found = 1'b1;
					// first fit, and the spare code, stop at the first hit
					stop  = (fit_mode_q != MODE_BEST) && (fit_mode_q != MODE_WORST);
				end else if (fit_mode_q == MODE_BEST && free_size[j] < free_size[pick]) begin
					pick = j;
				end else if (fit_mode_q == MODE_WORST && free_size[j] > free_size[pick]) begin
					pick = j;
				end
			end
		end
		if (found) begin
			free_size[pick]    = free_size[pick] - amt;
			res.granted        = 1'b1;
			res.chosen_block   = pick[IDX_FIELD_W-1:0];
			res.remaining_size = free_size[pick];
		end
		return res;
	endfunction

	function automatic int field_differs(input string field, input logic [AMT_FIELD_W-1:0] exp_v,
			input logic [AMT_FIELD_W-1:0] act_v);
		if (act_v !== exp_v) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, field, exp_v, act_v);
			return 1;
		end
		return 0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_size     = '{default: '0};
			fit_mode_q    = MODE_FIRST;
			block_count_q = COUNT_W'(NUM_BLOCKS_DEF);
			grant_q.delete();
			errs          = 0;
			results       = 0;
			grants        = 0;
			error_count  <= 0;
			outstanding  <= 0;
			result_count <= 0;
			grant_count  <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_FIT_MODE:    fit_mode_q    = cfg_data[MODE_W-1:0];
					CFG_BLOCK_COUNT: block_count_q = cfg_data[COUNT_W-1:0];
					default: ;
				endcase
			end
			// results first: a result never belongs to a request taken at the same edge
			if (m_axis_tvalid && m_axis_tready) begin
				got.granted        = m_axis_tuser;
				got.chosen_block   = m_axis_tdata[3:0];
				got.remaining_size = m_axis_tdata[19:4];
				if (grant_q.size() == 0) begin
					$display("%0t: unexpected result, granted %0d block %0d size %0d", $time,
						got.granted, got.chosen_block, got.remaining_size);
					errs++;
				end else begin
					want = grant_q.pop_front();
					errs += field_differs("granted", AMT_FIELD_W'(want.granted),
						AMT_FIELD_W'(got.granted));
					errs += field_differs("chosen_block", AMT_FIELD_W'(want.chosen_block),
						AMT_FIELD_W'(got.chosen_block));
					errs += field_differs("remaining_size", want.remaining_size,
						got.remaining_size);
					results++;
					if (want.granted)
						grants++;
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				if (s_axis_tuser == REQ_LOAD)
					free_size[s_axis_tdata[3:0]] = s_axis_tdata[19:4];
				else
					grant_q.push_back(predict_grant(s_axis_tdata[19:4]));
			end
			error_count  <= errs;
			outstanding  <= grant_q.size();
			result_count <= results;
			grant_count  <= grants;
		end
	end

endmodule

[dv/tb_fit_policy_block_allocator_top.sv]
`timescale 1ns / 100ps
// tb_fit_policy_block_allocator_top: stimulus and verdict for the block allocator.
// Depends on fpba_pkg, fit_policy_block_allocator_top and fpba_grant_checker.

module tb_fit_policy_block_allocator_top;

	import fpba_pkg::*;

	// the spare fit-mode code, which should act as first fit
	localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

	localparam int PHASES       = 8;    // register settings in the random part
	localparam int PHASE_REQS   = 228;  // requests per setting, ~1850 in all
	localparam int LOAD_PCT     = 35;
	localparam int IDLE_GUARD   = 24;   // outlasts the longest allocate, whose block_count is capped at 16
	localparam int HOLD_CYCLES  = 400;  // long receiver hold-off
	localparam int DRAIN_LIMIT  = 5000;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [23:0]           s_axis_tdata = '0;
	logic                  s_axis_tuser = 1'b0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [23:0]           m_axis_tdata;
	logic                  m_axis_tuser;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	int error_count;
	int outstanding;
	int result_count;
	int grant_count;

	// shared between stimulus and receiver
	bit calm = 1'b0;          // no idling on either side
	bit hold_off_req = 1'b0;  // asks the receiver for one long hold-off

	int loads_sent = 0;
	int allocs_sent = 0;
	int settings_run = 0;

	// opening sizes: ties at 100 and at 65535, an empty block, a block of one
	logic [AMT_FIELD_W-1:0] seed_size [NUM_BLOCKS_DEF] = '{
		16'd100, 16'd0, 16'd65535, 16'd100, 16'd1, 16'd300, 16'd600, 16'd900,
		16'd1200, 16'd1500, 16'd1800, 16'd2100, 16'd2400, 16'd2700, 16'd3000, 16'd65535
	};

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	fit_policy_block_allocator_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	fpba_grant_checker u_grant_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.error_count   (error_count),
		.outstanding   (outstanding),
		.result_count  (result_count),
		.grant_count   (grant_count)
	);

	// Offer one request from the next falling edge and hold it until taken.
	// Sometimes a burst of idle cycles goes first; valid only drops for it.
	task automatic push_request(input logic kind, input logic [IDX_FIELD_W-1:0] idx,
			input logic [AMT_FIELD_W-1:0] amt);
		int gap;
		if (!calm && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 19);
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= 24'($urandom_range(0, 24'hFFFFFF));
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= kind;
		s_axis_tdata  <= {4'b0, amt, idx};
		do @(posedge clk); while (!s_axis_tready);
		if (kind == REQ_LOAD)
			loads_sent++;
		else
			allocs_sent++;
	endtask

	// Stop offering, let every grant come back, then give a trailing load or
	// allocate time to finish so the block is idle for a register write.
	task automatic settle_block();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (outstanding != 0) @(posedge clk);
		repeat (IDLE_GUARD) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	// Sizes bunch up on small values and all-ones so that fits, ties and
	// refusals all turn up; the rest spread over the full range.
	function automatic logic [AMT_FIELD_W-1:0] pick_amount(input logic kind);
		int unsigned r;
		logic [AMT_FIELD_W-1:0] amt;
		r = $urandom_range(0, 99);
		if (kind == REQ_LOAD) begin
			if (r < 20)      amt = '1;
			else if (r < 45) amt = AMT_FIELD_W'($urandom_range(0, 7));
			else if (r < 70) amt = AMT_FIELD_W'($urandom_range(0, 4095));
			else             amt = AMT_FIELD_W'($urandom_range(0, 65535));
		end else begin
			if (r < 10)      amt = '0;
			else if (r < 15) amt = '1;
			else if (r < 45) amt = AMT_FIELD_W'($urandom_range(0, 7));
			else if (r < 80) amt = AMT_FIELD_W'($urandom_range(0, 1023));
			else             amt = AMT_FIELD_W'($urandom_range(0, 65535));
		end
		return amt;
	endfunction

	// Receiver: random stalls, one long hold-off on request, none when calm.
	initial begin
		int stall;
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
			end else if (!calm && arst_n && $urandom_range(0, 5) == 0) begin
				stall = $urandom_range(1, 19);
				m_axis_tready <= 1'b0;
				repeat (stall - 1) @(negedge clk);
			end else begin
				m_axis_tready <= arst_n;
			end
		end
	end

	// Stimulus
	initial begin
		int i;
		int p;
		int n;
		int waited;
		logic kind;
		logic [MODE_W-1:0]  mode;
		logic [COUNT_W-1:0] count;

		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		// Directed part. Every block gets loaded first, so no allocate ever
		// scans an unwritten entry, whatever block_count says later.
		for (i = 0; i < NUM_BLOCKS_DEF; i++)
			push_request(REQ_LOAD, i[IDX_FIELD_W-1:0], seed_size[i]);

		// reset setting: first fit over 16 blocks
		push_request(REQ_ALLOC, 4'hA, 16'd0);     // zero request: block 0 keeps 100
		push_request(REQ_ALLOC, 4'h0, 16'hFFFF);  // exact fit in block 2
		push_request(REQ_ALLOC, 4'hF, 16'hFFFF);  // next all-ones block, 15
		push_request(REQ_ALLOC, 4'h5, 16'hFFFF);  // nothing left that large
		settle_block();

		// best fit, tie between blocks 0 and 3 goes to 0
		write_reg(CFG_FIT_MODE, MODE_BEST);
		push_request(REQ_ALLOC, 4'h3, 16'd100);
		settle_block();

		// worst fit with an oversized count, which saturates at 16
		write_reg(CFG_FIT_MODE, MODE_WORST);
		write_reg(CFG_BLOCK_COUNT, 5'd31);
		push_request(REQ_ALLOC, 4'h9, 16'd1);
		settle_block();

		// spare mode code and no block in use: always refused
		write_reg(CFG_FIT_MODE, MODE_SPARE);
		write_reg(CFG_BLOCK_COUNT, 5'd0);
		push_request(REQ_ALLOC, 4'hC, 16'd0);
		settle_block();

		// a single block in use
		write_reg(CFG_FIT_MODE, MODE_FIRST);
		write_reg(CFG_BLOCK_COUNT, 5'd1);
		push_request(REQ_ALLOC, 4'h6, 16'd0);
		settle_block();
		settings_run = 5;

		// Random part, one register setting per phase
		for (p = 0; p < PHASES; p++) begin
			case (p)
				0: begin mode = MODE_BEST;  count = 5'd16; end
				1: begin mode = MODE_WORST; count = 5'd16; end
				2: begin mode = MODE_FIRST; count = 5'd5;  end
				3: begin mode = MODE_SPARE; count = 5'd17; end
				4: begin mode = MODE_BEST;  count = 5'd1;  end
				5: begin mode = MODE_WORST; count = 5'd31; end
				default: begin
					mode  = MODE_W'($urandom_range(0, 3));
					count = COUNT_W'($urandom_range(1, 31));
				end
			endcase
			write_reg(CFG_FIT_MODE, mode);
			write_reg(CFG_BLOCK_COUNT, count);
			settings_run++;

			// fill the block up behind a stalled receiver once
			if (p == 2)
				hold_off_req = 1'b1;
			// last phase runs flat out on both sides
			if (p == PHASES - 1)
				calm = 1'b1;

			for (n = 0; n < PHASE_REQS; n++) begin
				kind = ($urandom_range(0, 99) < LOAD_PCT) ? REQ_LOAD : REQ_ALLOC;
				push_request(kind, IDX_FIELD_W'($urandom_range(0, 15)), pick_amount(kind));
			end
			settle_block();
		end

		// Drain: settle_block has already waited for the last grants; the
		// bounded loop below only guards the verdict.
		waited = 0;
		while (outstanding != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (IDLE_GUARD) @(posedge clk);

		$display("Covered %0d loads and %0d allocates over %0d register settings.",
			loads_sent, allocs_sent, settings_run);
		$display("Checked %0d results: %0d granted, %0d refused; %0d still awaited.",
			result_count, grant_count, result_count - grant_count, outstanding);
		if (error_count == 0 && outstanding == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	// Watchdog: well beyond the slowest legal run (~2.5 ms)
	initial begin
		#20_000_000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

[sim.f]
src/fpba_pkg.sv
src/fpba_table.sv
src/fpba_ctrl.sv
src/fit_policy_block_allocator_top.sv
dv/fpba_grant_checker.sv
dv/tb_fit_policy_block_allocator_top.sv
